/* rtl/core/qnl_pkg.sv */
// ----------------------------------------------------------------------------
// qnl_pkg: shared types and constants
// Field layout of the transactions and the fixed widths of the datapath.
// ----------------------------------------------------------------------------
package qnl_pkg;

    localparam int NUM_LANES  = 4;
    localparam int COMP_W     = 16;
    localparam int BLEND_W    = 17;
    localparam int MAG_W      = 32;
    localparam int V_W        = 30;
    localparam int SQ_W       = 2 * V_W;
    localparam int SUM_W      = 62;
    localparam int ROOT_W     = 32;
    localparam int SQRT_STEPS = 31;
    localparam int Q_W        = 16;
    localparam int DIV_STEPS  = 16;
    localparam int NUM_W      = 46;
    localparam int DEN_W      = ROOT_W + 1;
    localparam int CMP_W      = NUM_W + 3;
    localparam int POS_W      = 5;

    localparam logic [BLEND_W-1:0] T_ONE    = 17'd65536;
    localparam logic [POS_W-1:0]   NORM_POS = 5'd29;

    typedef struct packed {
        logic signed [COMP_W-1:0] a_w;
        logic signed [COMP_W-1:0] a_x;
        logic signed [COMP_W-1:0] a_y;
        logic signed [COMP_W-1:0] a_z;
        logic signed [COMP_W-1:0] b_w;
        logic signed [COMP_W-1:0] b_x;
        logic signed [COMP_W-1:0] b_y;
        logic signed [COMP_W-1:0] b_z;
        logic [BLEND_W-1:0]       blend;
    } t_in_item;

    typedef struct packed {
        logic signed [COMP_W-1:0] out_w;
        logic signed [COMP_W-1:0] out_x;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_z;
        logic                     degenerate;
    } t_out_item;

    typedef struct packed {
        logic [NUM_LANES-1:0][V_W-1:0] v;
        logic [NUM_LANES-1:0]          neg;
        logic                          zero;
    } t_side;

endpackage

/* rtl/core/qnl_lane.sv */
// ----------------------------------------------------------------------------
// qnl_lane: per-component blend
// Forms (1-t)*a + t*b' for one component and splits it into magnitude and sign.
// ----------------------------------------------------------------------------
module qnl_lane (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [qnl_pkg::COMP_W-1:0] i_a,
    input  logic signed [qnl_pkg::COMP_W-1:0] i_b,
    input  logic [qnl_pkg::BLEND_W-1:0]       i_t,
    input  logic                              i_flip,
    output logic                              o_valid,
    output logic [qnl_pkg::MAG_W-1:0]         o_mag,
    output logic                              o_neg
);

    logic signed [17:0] wa;
    logic signed [17:0] wb;
    logic signed [16:0] bb;
    logic signed [33:0] n_m0;
    logic signed [33:0] n_m1;
    logic signed [33:0] sum;
    logic signed [33:0] r_m0;
    logic signed [33:0] r_m1;
    logic               r_v1;

    assign wa   = $signed({1'b0, qnl_pkg::T_ONE - i_t});
    assign wb   = $signed({1'b0, i_t});
    // take the short arc: negate b when the dot product is negative
    assign bb   = i_flip ? -$signed({i_b[15], i_b}) : $signed({i_b[15], i_b});
    assign n_m0 = wa * i_a;
    assign n_m1 = wb * bb;
    assign sum  = r_m0 + r_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            o_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m0  <= n_m0;
            r_m1  <= n_m1;
            o_mag <= sum[33] ? 32'(-sum) : 32'(sum);
            o_neg <= sum[33];
        end
    end

endmodule

/* rtl/core/qnl_merge.sv */
// ----------------------------------------------------------------------------
// qnl_merge: lane merge and block normalization
// Finds the largest magnitude, shifts all lanes by one common amount so the
// largest lies in [2^29, 2^30), and sums the squares.
// ----------------------------------------------------------------------------
module qnl_merge (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_en,
    input  logic                                                i_valid,
    input  logic [qnl_pkg::NUM_LANES-1:0][qnl_pkg::MAG_W-1:0]   i_mag,
    input  logic [qnl_pkg::NUM_LANES-1:0]                       i_neg,
    output logic                                                o_valid,
    output logic [qnl_pkg::SUM_W-1:0]                           o_sum,
    output qnl_pkg::t_side                                      o_side
);

    logic [4:0]                                            r_v;
    logic [qnl_pkg::MAG_W-1:0]                             m01;
    logic [qnl_pkg::MAG_W-1:0]                             m23;
    logic [qnl_pkg::MAG_W-1:0]                             r1_max;
    logic [qnl_pkg::NUM_LANES-1:0][qnl_pkg::MAG_W-1:0]     r1_mag;
    logic [qnl_pkg::NUM_LANES-1:0][qnl_pkg::MAG_W-1:0]     r2_mag;
    logic [qnl_pkg::NUM_LANES-1:0]                         r1_neg;
    logic [qnl_pkg::NUM_LANES-1:0]                         r2_neg;
    logic [qnl_pkg::NUM_LANES-1:0]                         r3_neg;
    logic [qnl_pkg::NUM_LANES-1:0]                         r4_neg;
    logic                                                  r2_zero;
    logic                                                  r3_zero;
    logic                                                  r4_zero;
    logic [qnl_pkg::POS_W-1:0]                             pos;
    logic [1:0]                                            n_rsh;
    logic [qnl_pkg::POS_W-1:0]                             n_lsh;
    logic [1:0]                                            r2_rsh;
    logic [qnl_pkg::POS_W-1:0]                             r2_lsh;
    logic [qnl_pkg::NUM_LANES-1:0][qnl_pkg::V_W-1:0]       r3_v;
    logic [qnl_pkg::NUM_LANES-1:0][qnl_pkg::V_W-1:0]       r4_v;
    logic [qnl_pkg::NUM_LANES-1:0][qnl_pkg::SQ_W-1:0]      r4_sq;

    assign m01 = (i_mag[0] > i_mag[1]) ? i_mag[0] : i_mag[1];
    assign m23 = (i_mag[2] > i_mag[3]) ? i_mag[2] : i_mag[3];

    always_comb begin
        pos = '0;
        for (int i = 0; i < qnl_pkg::MAG_W; i++) begin
            if (r1_max[i]) pos = qnl_pkg::POS_W'(i);
        end
        if (pos >= qnl_pkg::NORM_POS) begin
            n_rsh = 2'(pos - qnl_pkg::NORM_POS);
            n_lsh = '0;
        end else begin
            n_rsh = '0;
            n_lsh = qnl_pkg::NORM_POS - pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_max  <= (m01 > m23) ? m01 : m23;
            r1_mag  <= i_mag;
            r1_neg  <= i_neg;
            r2_mag  <= r1_mag;
            r2_neg  <= r1_neg;
            r2_zero <= (r1_max == '0);
            r2_rsh  <= n_rsh;
            r2_lsh  <= n_lsh;
            for (int c = 0; c < qnl_pkg::NUM_LANES; c++) begin
                r3_v[c]  <= qnl_pkg::V_W'((r2_mag[c] >> r2_rsh) << r2_lsh);
                r4_sq[c] <= qnl_pkg::SQ_W'(r3_v[c]) * qnl_pkg::SQ_W'(r3_v[c]);
            end
            r3_neg  <= r2_neg;
            r3_zero <= r2_zero;
            r4_v    <= r3_v;
            r4_neg  <= r3_neg;
            r4_zero <= r3_zero;
            o_sum   <= qnl_pkg::SUM_W'(r4_sq[0]) + qnl_pkg::SUM_W'(r4_sq[1])
                     + qnl_pkg::SUM_W'(r4_sq[2]) + qnl_pkg::SUM_W'(r4_sq[3]);
            o_side.v    <= r4_v;
            o_side.neg  <= r4_neg;
            o_side.zero <= r4_zero;
        end
    end

    assign o_valid = r_v[4];

endmodule

/* rtl/core/qnl_isqrt.sv */
// ----------------------------------------------------------------------------
// qnl_isqrt: pipelined integer square root
// One result bit per stage, floor(sqrt(sum)), with the lane data riding along.
// ----------------------------------------------------------------------------
module qnl_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [qnl_pkg::SUM_W-1:0]    i_sum,
    input  qnl_pkg::t_side               i_side,
    output logic                         o_valid,
    output logic [qnl_pkg::ROOT_W-1:0]   o_root,
    output qnl_pkg::t_side               o_side
);

    localparam int LAST = qnl_pkg::SQRT_STEPS - 1;

    logic [qnl_pkg::SQRT_STEPS-1:0] r_v;
    logic [qnl_pkg::SUM_W-1:0]      r_rem  [qnl_pkg::SQRT_STEPS];
    logic [qnl_pkg::SUM_W-1:0]      r_res  [qnl_pkg::SQRT_STEPS];
    qnl_pkg::t_side                 r_side [qnl_pkg::SQRT_STEPS];
    logic                           p_v    [qnl_pkg::SQRT_STEPS];
    logic [qnl_pkg::SUM_W-1:0]      p_rem  [qnl_pkg::SQRT_STEPS];
    logic [qnl_pkg::SUM_W-1:0]      p_res  [qnl_pkg::SQRT_STEPS];
    qnl_pkg::t_side                 p_side [qnl_pkg::SQRT_STEPS];

    for (genvar k = 0; k < qnl_pkg::SQRT_STEPS; k++) begin : g_step
        localparam logic [qnl_pkg::SUM_W-1:0] BIT =
            qnl_pkg::SUM_W'(1) << (qnl_pkg::SUM_W - 2 - 2 * k);
        logic [qnl_pkg::SUM_W-1:0] cand;

        if (k == 0) begin : g_first
            assign p_v[k]    = i_valid;
            assign p_rem[k]  = i_sum;
            assign p_res[k]  = '0;
            assign p_side[k] = i_side;
        end else begin : g_next
            assign p_v[k]    = r_v[k-1];
            assign p_rem[k]  = r_rem[k-1];
            assign p_res[k]  = r_res[k-1];
            assign p_side[k] = r_side[k-1];
        end

        assign cand = p_res[k] + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= p_side[k];
                if (p_rem[k] >= cand) begin
                    r_rem[k] <= p_rem[k] - cand;
                    r_res[k] <= (p_res[k] >> 1) + BIT;
                end else begin
                    r_rem[k] <= p_rem[k];
                    r_res[k] <= p_res[k] >> 1;
                end
            end
        end
    end

    assign o_valid = r_v[LAST];
    assign o_root  = r_res[LAST][qnl_pkg::ROOT_W-1:0];
    assign o_side  = r_side[LAST];

endmodule

/* rtl/core/qnl_div.sv */
// ----------------------------------------------------------------------------
// qnl_div: per-component rounded divide and sign restore
// Restoring divider, one quotient bit per stage, for
// (32768*v + n) / (2n), then sign, saturation and the zero-length case.
// ----------------------------------------------------------------------------
module qnl_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [qnl_pkg::V_W-1:0]           i_v,
    input  logic [qnl_pkg::ROOT_W-1:0]        i_root,
    input  logic                              i_neg,
    input  logic                              i_zero,
    output logic                              o_valid,
    output logic signed [qnl_pkg::COMP_W-1:0] o_comp,
    output logic                              o_zero
);

    localparam int LAST = qnl_pkg::DIV_STEPS - 1;

    logic [qnl_pkg::DIV_STEPS-1:0] r_v;
    logic [qnl_pkg::NUM_W-1:0]     r_rem  [qnl_pkg::DIV_STEPS];
    logic [qnl_pkg::DEN_W-1:0]     r_den  [qnl_pkg::DIV_STEPS];
    logic [qnl_pkg::Q_W-1:0]       r_q    [qnl_pkg::DIV_STEPS];
    logic                          r_neg  [qnl_pkg::DIV_STEPS];
    logic                          r_zero [qnl_pkg::DIV_STEPS];
    logic                          p_v    [qnl_pkg::DIV_STEPS];
    logic [qnl_pkg::NUM_W-1:0]     p_rem  [qnl_pkg::DIV_STEPS];
    logic [qnl_pkg::DEN_W-1:0]     p_den  [qnl_pkg::DIV_STEPS];
    logic [qnl_pkg::Q_W-1:0]       p_q    [qnl_pkg::DIV_STEPS];
    logic                          p_neg  [qnl_pkg::DIV_STEPS];
    logic                          p_zero [qnl_pkg::DIV_STEPS];
    logic [qnl_pkg::Q_W-1:0]       qs;
    logic signed [qnl_pkg::Q_W:0]  sv;

    for (genvar k = 0; k < qnl_pkg::DIV_STEPS; k++) begin : g_step
        localparam int SH = qnl_pkg::DIV_STEPS - 1 - k;
        logic [qnl_pkg::CMP_W-1:0] dsh;

        if (k == 0) begin : g_first
            assign p_v[k]    = i_valid;
            assign p_rem[k]  = qnl_pkg::NUM_W'({i_v, 15'b0}) + qnl_pkg::NUM_W'(i_root);
            assign p_den[k]  = {i_root, 1'b0};
            assign p_q[k]    = '0;
            assign p_neg[k]  = i_neg;
            assign p_zero[k] = i_zero;
        end else begin : g_next
            assign p_v[k]    = r_v[k-1];
            assign p_rem[k]  = r_rem[k-1];
            assign p_den[k]  = r_den[k-1];
            assign p_q[k]    = r_q[k-1];
            assign p_neg[k]  = r_neg[k-1];
            assign p_zero[k] = r_zero[k-1];
        end

        assign dsh = qnl_pkg::CMP_W'(p_den[k]) << SH;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k]  <= p_den[k];
                r_neg[k]  <= p_neg[k];
                r_zero[k] <= p_zero[k];
                if (qnl_pkg::CMP_W'(p_rem[k]) >= dsh) begin
                    r_rem[k] <= p_rem[k] - dsh[qnl_pkg::NUM_W-1:0];
                    r_q[k]   <= p_q[k] | (qnl_pkg::Q_W'(1) << SH);
                end else begin
                    r_rem[k] <= p_rem[k];
                    r_q[k]   <= p_q[k];
                end
            end
        end
    end

    always_comb begin
        qs = (r_q[LAST] > 16'd32768) ? 16'd32768 : r_q[LAST];
        sv = r_neg[LAST] ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
        if (sv > 17'sd32767) sv = 17'sd32767;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_comp <= r_zero[LAST] ? '0 : sv[qnl_pkg::COMP_W-1:0];
            o_zero <= r_zero[LAST];
        end
    end

endmodule

/* rtl/core/quat_nlerp_unit.sv */
// ----------------------------------------------------------------------------
// quat_nlerp_unit: quaternion normalized linear interpolation
// Blends two Q2.14 quaternions along the short arc and scales to unit length.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / o_stall carries i_data (both quaternions and the
//   blend factor); a transaction is taken when i_valid is high and o_stall
//   is low. Output channel o_valid / i_stall carries o_data with the four
//   normalized components and the degenerate flag.
//   One transaction enters per cycle while the output keeps draining. Each
//   result passes through 2 dot-product stages, 2 blend stages in four
//   component lanes, 5 merge/normalize stages, 31 square-root stages (one
//   root bit each), 16 divide stages per lane (one quotient bit each), a
//   sign and saturation register per lane and the output register.
//   When the receiver stalls, the result holds in the output register and
//   one more result lands in a skid register; only then does o_stall rise
//   and the whole pipeline freeze until the stall drops.
//   Reset empties the pipeline and the output; the block keeps no other
//   state, so no warm-up is needed.
// ----------------------------------------------------------------------------
module quat_nlerp_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  qnl_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output qnl_pkg::t_out_item o_data
);

    localparam int NL = qnl_pkg::NUM_LANES;

    logic                               en;
    logic [qnl_pkg::BLEND_W-1:0]        tsat;
    logic signed [qnl_pkg::COMP_W-1:0]  in_a [NL];
    logic signed [qnl_pkg::COMP_W-1:0]  in_b [NL];
    logic                               r1_v;
    logic                               r2_v;
    logic signed [qnl_pkg::COMP_W-1:0]  r1_a [NL];
    logic signed [qnl_pkg::COMP_W-1:0]  r1_b [NL];
    logic signed [qnl_pkg::COMP_W-1:0]  r2_a [NL];
    logic signed [qnl_pkg::COMP_W-1:0]  r2_b [NL];
    logic signed [31:0]                 r1_p [NL];
    logic [qnl_pkg::BLEND_W-1:0]        r1_t;
    logic [qnl_pkg::BLEND_W-1:0]        r2_t;
    logic signed [33:0]                 dot;
    logic                               r2_flip;
    logic [NL-1:0]                      lane_v;
    logic [NL-1:0][qnl_pkg::MAG_W-1:0]  lane_mag;
    logic [NL-1:0]                      lane_neg;
    logic                               mrg_v;
    logic [qnl_pkg::SUM_W-1:0]          mrg_sum;
    qnl_pkg::t_side                     mrg_side;
    logic                               sq_v;
    logic [qnl_pkg::ROOT_W-1:0]         sq_root;
    qnl_pkg::t_side                     sq_side;
    logic [NL-1:0]                      div_v;
    logic signed [qnl_pkg::COMP_W-1:0]  div_comp [NL];
    logic [NL-1:0]                      div_zero;
    qnl_pkg::t_out_item                 p_data;
    logic                               r_o_v;
    qnl_pkg::t_out_item                 r_o_d;
    logic                               r_s_v;
    qnl_pkg::t_out_item                 r_s_d;

    assign en      = !r_s_v;
    assign o_stall = r_s_v;

    assign tsat = (i_data.blend > qnl_pkg::T_ONE) ? qnl_pkg::T_ONE : i_data.blend;
    assign in_a[0] = i_data.a_w;
    assign in_a[1] = i_data.a_x;
    assign in_a[2] = i_data.a_y;
    assign in_a[3] = i_data.a_z;
    assign in_b[0] = i_data.b_w;
    assign in_b[1] = i_data.b_x;
    assign in_b[2] = i_data.b_y;
    assign in_b[3] = i_data.b_z;

    assign dot = 34'(r1_p[0]) + 34'(r1_p[1]) + 34'(r1_p[2]) + 34'(r1_p[3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < NL; c++) begin
                r1_a[c] <= in_a[c];
                r1_b[c] <= in_b[c];
                r1_p[c] <= in_a[c] * in_b[c];
            end
            r1_t    <= tsat;
            r2_a    <= r1_a;
            r2_b    <= r1_b;
            r2_t    <= r1_t;
            // a zero dot product keeps b as it is
            r2_flip <= dot[33];
        end
    end

    for (genvar c = 0; c < NL; c++) begin : g_lane
        qnl_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (r2_v),
            .i_a     (r2_a[c]),
            .i_b     (r2_b[c]),
            .i_t     (r2_t),
            .i_flip  (r2_flip),
            .o_valid (lane_v[c]),
            .o_mag   (lane_mag[c]),
            .o_neg   (lane_neg[c])
        );
    end

    qnl_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (lane_v[0]),
        .i_mag   (lane_mag),
        .i_neg   (lane_neg),
        .o_valid (mrg_v),
        .o_sum   (mrg_sum),
        .o_side  (mrg_side)
    );

    qnl_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (mrg_v),
        .i_sum   (mrg_sum),
        .i_side  (mrg_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    for (genvar c = 0; c < NL; c++) begin : g_div
        qnl_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v),
            .i_v     (sq_side.v[c]),
            .i_root  (sq_root),
            .i_neg   (sq_side.neg[c]),
            .i_zero  (sq_side.zero),
            .o_valid (div_v[c]),
            .o_comp  (div_comp[c]),
            .o_zero  (div_zero[c])
        );
    end

    assign p_data.out_w      = div_comp[0];
    assign p_data.out_x      = div_comp[1];
    assign p_data.out_y      = div_comp[2];
    assign p_data.out_z      = div_comp[3];
    assign p_data.degenerate = div_zero[0];

    // output register plus skid: the pipeline only freezes once the skid fills
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
            r_s_v <= 1'b0;
        end else if (r_s_v) begin
            if (!i_stall) begin
                r_o_v <= 1'b1;
                r_s_v <= 1'b0;
            end
        end else if (!r_o_v || !i_stall) begin
            r_o_v <= div_v[0];
        end else if (div_v[0]) begin
            r_s_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s_v) begin
            if (!i_stall) r_o_d <= r_s_d;
        end else if (!r_o_v || !i_stall) begin
            r_o_d <= p_data;
        end else begin
            r_s_d <= p_data;
        end
    end

    assign o_valid = r_o_v;
    assign o_data  = r_o_d;

    a_skid_only_behind_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("skid holds a transaction while the output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("skid filled without a stalled output");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.degenerate) |->
        (o_data.out_w == '0 && o_data.out_x == '0 && o_data.out_y == '0
         && o_data.out_z == '0))
        else $error("degenerate result with nonzero components");

endmodule
